FILE: hdl/heap_sort_engine_defines.svh
// Assertion macros for the heap sort engine checker.
// Depends on nothing; expects i_clk and i_rst_n in the scope of use.
`ifndef HEAP_SORT_ENGINE_DEFINES_SVH
`define HEAP_SORT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define HSE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hse_pkg.sv
// Shared types for the heap sort engine: word type, command and status bundles.
// No dependencies.
`default_nettype none

package hse_pkg;

    localparam int unsigned WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;    // take input words
        logic build_init;  // start heap build over the loaded set
        logic heap_load;   // read the next build node
        logic cur_load;    // capture the value being sifted
        logic sift_rd;     // read both children of the current node
        logic sift_cmp;    // compare and move one level down
        logic k_dec;       // step the loop counter down
        logic sort_init;   // start the extraction loop
        logic swap_rd;     // read root and last unsorted entry
        logic swap_wr;     // park the root at the end of the heap
        logic out_init;    // rewind the read-out index
        logic out_rd;      // read the next sorted entry
        logic out_ld;      // load the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_acc;    // a word flagged last was taken
        logic small_set;   // the closed set holds a single element
        logic move;        // a child is larger than the sifted value
        logic k_one;       // loop counter equals one
        logic k_two;       // loop counter equals two
        logic out_free;    // output register can take a word
        logic out_last;    // read-out index is on the final element
    } t_stat;

endpackage

`default_nettype wire

FILE: hdl/hse_if.sv
// Valid/ready channel interfaces for the heap sort engine input and result words.
// Depends on hse_pkg for the word type.
`default_nettype none

interface hse_in_if;
    import hse_pkg::*;

    logic  valid;
    logic  ready;
    t_word value;
    logic  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface hse_out_if;
    import hse_pkg::*;

    logic  valid;
    logic  ready;
    t_word sorted_value;
    logic  last_out;
    logic  overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/heap_sort_engine.sv
// Heap sort engine top level: joins the sequencer and the datapath.
// Depends on hse_pkg, hse_if, hse_ctrl and hse_dp.
//
// Usage: signed 32-bit words arrive on i_in (valid/ready), one per cycle while
// ready is high; the word flagged last closes the set. Up to DEPTH words are
// kept; further words are dropped and every result of that set carries overflow.
// Once the set is closed, ready stays low while the block builds a max-heap in
// its element memory and extracts it in place, then streams the set in
// ascending order on o_res, last_out marking the final word.
// Steps for a set of n words: each sift level reads both children, then compares
// and writes; each build or extraction step adds set-up states (node load and
// value capture, or root read and swap write), and read-out reads each word and
// then loads it into the output register.
// Reset is synchronous and empties the set; memory contents are not cleared.
// When the receiver stalls, the output register holds its word and read-out
// waits; after the final word is loaded there, ready rises for the next set.
`default_nettype none

module heap_sort_engine
    import hse_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hse_in_if.sink     i_in,
    hse_out_if.source  o_res
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    hse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Memory, sift unit and output register
    hse_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

FILE: hdl/hse_ctrl.sv
// Sequencer for the heap sort engine: load, heap build, extraction and read-out.
// Depends on hse_pkg for the command and status bundles.
`default_nettype none

module hse_ctrl
    import hse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_HEAP_LD  = 9'b000000010,
        ST_HEAP_CUR = 9'b000000100,
        ST_SIFT_RD  = 9'b000001000,
        ST_SIFT_CMP = 9'b000010000,
        ST_SWAP_RD  = 9'b000100000,
        ST_SWAP_WR  = 9'b001000000,
        ST_OUT_RD   = 9'b010000000,
        ST_OUT_LD   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_sorting;
    logic   n_sorting;

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_sorting = r_sorting;
        o_cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.last_acc) begin
                    if (i_stat.small_set) begin
                        o_cmd.out_init = 1'b1;
                        n_state        = ST_OUT_RD;
                    end else begin
                        o_cmd.build_init = 1'b1;
                        n_sorting        = 1'b0;
                        n_state          = ST_HEAP_LD;
                    end
                end
            end
            ST_HEAP_LD: begin
                o_cmd.heap_load = 1'b1;
                n_state         = ST_HEAP_CUR;
            end
            ST_HEAP_CUR: begin
                o_cmd.cur_load = 1'b1;
                n_state        = ST_SIFT_RD;
            end
            ST_SIFT_RD: begin
                o_cmd.sift_rd = 1'b1;
                n_state       = ST_SIFT_CMP;
            end
            ST_SIFT_CMP: begin
                o_cmd.sift_cmp = 1'b1;
                if (i_stat.move) begin
                    n_state = ST_SIFT_RD;
                end else if (!r_sorting) begin
                    // build sift done: start extraction once the root is done, else load the next node
                    if (i_stat.k_one) begin
                        o_cmd.sort_init = 1'b1;
                        n_sorting       = 1'b1;
                        n_state         = ST_SWAP_RD;
                    end else begin
                        o_cmd.k_dec = 1'b1;
                        n_state     = ST_HEAP_LD;
                    end
                end else begin
                    // extraction sift done: after the last swap the store is in ascending order, else swap again
                    if (i_stat.k_two) begin
                        o_cmd.out_init = 1'b1;
                        n_state        = ST_OUT_RD;
                    end else begin
                        o_cmd.k_dec = 1'b1;
                        n_state     = ST_SWAP_RD;
                    end
                end
            end
            ST_SWAP_RD: begin
                o_cmd.swap_rd = 1'b1;
                n_state       = ST_SWAP_WR;
            end
            ST_SWAP_WR: begin
                o_cmd.swap_wr = 1'b1;
                n_state       = ST_SIFT_RD;
            end
            ST_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = i_stat.out_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sorting <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sorting <= n_sorting;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hse_dp.sv
// Datapath of the heap sort engine: element memory, sift unit, counters, output register.
// Depends on hse_pkg and the channel interfaces in hse_if.
`default_nettype none

module hse_dp
    import hse_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    hse_in_if.sink           i_in,
    hse_out_if.source        o_res
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = AW + 2;

    // Element memory and its registered read data
    t_word          r_mem [DEPTH];
    t_word          r_rd_a;
    t_word          r_rd_b;

    // Control registers
    logic [CW-1:0]  r_cnt;
    logic           r_drop;
    logic           r_ovalid;

    // Working registers
    logic [CW-1:0]  r_size;
    logic [CW-1:0]  r_k;
    logic [AW-1:0]  r_node;
    t_word          r_cur;
    logic [AW-1:0]  r_idx;
    t_word          r_out_val;
    logic           r_out_last;
    logic           r_out_ovf;

    logic           acc;
    logic           cnt_full;
    logic [CW-1:0]  cnt_after;
    logic [CW-1:0]  k_less;
    logic [AW-1:0]  k_addr;
    logic [XW-1:0]  left_idx;
    logic [XW-1:0]  right_idx;
    logic [XW-1:0]  size_x;
    logic           left_ok;
    logic           right_ok;
    logic           pick_r;
    t_word          big_val;
    logic [AW-1:0]  big_idx;
    logic           move;
    logic           out_last;

    logic           rd_en;
    logic [AW-1:0]  rd_addr_a;
    logic [AW-1:0]  rd_addr_b;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    t_word          wr_data;

    // Input side
    assign i_in.ready = i_cmd.in_ready;
    assign acc        = i_in.valid & i_cmd.in_ready;
    assign cnt_full   = (r_cnt == CW'(DEPTH));
    assign cnt_after  = cnt_full ? r_cnt : r_cnt + CW'(1);

    // Loop counter minus one, as an address
    assign k_less = r_k - CW'(1);
    assign k_addr = k_less[AW-1:0];

    // Sift compare: pick the larger live child, move it up if it beats the held value
    assign left_idx  = {1'b0, r_node, 1'b1};
    assign right_idx = left_idx + XW'(1);
    assign size_x    = XW'(r_size);
    assign left_ok   = (left_idx < size_x);
    assign right_ok  = (right_idx < size_x);
    assign pick_r    = right_ok && (r_rd_b > r_rd_a);
    assign big_val   = pick_r ? r_rd_b : r_rd_a;
    assign big_idx   = pick_r ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign move      = left_ok && (big_val > r_cur);

    assign out_last  = ((CW'(r_idx) + CW'(1)) == r_cnt);

    // Status back to the controller
    assign o_stat.last_acc  = acc & i_in.last;
    assign o_stat.small_set = (cnt_after < CW'(2));
    assign o_stat.move      = move;
    assign o_stat.k_one     = (r_k == CW'(1));
    assign o_stat.k_two     = (r_k == CW'(2));
    assign o_stat.out_free  = !r_ovalid || o_res.ready;
    assign o_stat.out_last  = out_last;

    // Read port addresses
    always_comb begin
        rd_en     = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        if (i_cmd.heap_load) begin
            rd_en     = 1'b1;
            rd_addr_a = k_addr;
        end else if (i_cmd.sift_rd) begin
            rd_en     = 1'b1;
            rd_addr_a = left_idx[AW-1:0];
            rd_addr_b = right_idx[AW-1:0];
        end else if (i_cmd.swap_rd) begin
            rd_en     = 1'b1;
            rd_addr_b = k_addr;
        end else if (i_cmd.out_rd) begin
            rd_en     = 1'b1;
            rd_addr_a = r_idx;
        end
    end

    // Write port: loading, sift moves and the root swap never overlap
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = i_in.value;
        if (acc && !cnt_full) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt[AW-1:0];
        end else if (i_cmd.sift_cmp) begin
            wr_en   = 1'b1;
            wr_addr = r_node;
            wr_data = move ? big_val : r_cur;
        end else if (i_cmd.swap_wr) begin
            wr_en   = 1'b1;
            wr_addr = k_addr;
            wr_data = r_rd_a;
        end
    end

    // Element memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    // Count, drop flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (acc) begin
                r_cnt <= cnt_after;
                if (cnt_full) begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
                if (out_last) begin
                    r_cnt  <= '0;
                    r_drop <= 1'b0;
                end
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working registers of the sort
    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_k    <= cnt_after >> 1;
            r_size <= cnt_after;
        end
        if (i_cmd.heap_load) begin
            r_node <= k_addr;
        end
        if (i_cmd.cur_load) begin
            r_cur <= r_rd_a;
        end
        if (i_cmd.sift_cmp && move) begin
            r_node <= big_idx;
        end
        if (i_cmd.k_dec) begin
            r_k <= k_less;
        end
        if (i_cmd.sort_init) begin
            r_k <= r_cnt;
        end
        if (i_cmd.swap_wr) begin
            r_cur  <= r_rd_b;
            r_node <= '0;
            r_size <= k_less;
        end
        if (i_cmd.out_init) begin
            r_idx <= '0;
        end
        if (i_cmd.out_ld) begin
            r_out_val  <= r_rd_a;
            r_out_last <= out_last;
            r_out_ovf  <= r_drop;
            if (!out_last) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    // Result channel
    assign o_res.valid        = r_ovalid;
    assign o_res.sorted_value = r_out_val;
    assign o_res.last_out     = r_out_last;
    assign o_res.overflow     = r_out_ovf;

endmodule

`default_nettype wire

FILE: hdl/heap_sort_engine_checker.sv
// Port-level checker for the heap sort engine and its bind to the top level.
// Depends on hse_pkg and heap_sort_engine_defines.svh.
`default_nettype none

`include "heap_sort_engine_defines.svh"

module heap_sort_engine_checker
    import hse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_ready,
    input  logic  i_in_last,
    input  logic  i_res_valid,
    input  logic  i_res_ready,
    input  t_word i_res_value,
    input  logic  i_res_last,
    input  logic  i_res_ovf
);

    logic [1:0] r_sets;
    logic       set_in;
    logic       set_out;

    assign set_in  = i_in_valid && i_in_ready && i_in_last;
    assign set_out = i_res_valid && i_res_ready && i_res_last;

    // Track closed sets whose final word is not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sets <= '0;
        end else if (set_in && !set_out) begin
            r_sets <= r_sets + 2'd1;
        end else if (set_out && !set_in) begin
            r_sets <= r_sets - 2'd1;
        end
    end

    `HSE_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_value) && $stable(i_res_last) && $stable(i_res_ovf), "stalled result word changed")
    `HSE_ASSERT_IMPL(a_ready_drop, $fell(i_in_ready), $past(i_in_valid && i_in_last), "input closed without a last word")
    `HSE_ASSERT_IMPL(a_res_owned, i_res_valid, r_sets != 2'd0, "result word with no closed set")
    `HSE_ASSERT_IMPL(a_sets_bound, 1'b1, r_sets != 2'd3, "more than two sets in flight")

endmodule

bind heap_sort_engine heap_sort_engine_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_value (o_res.sorted_value),
    .i_res_last  (o_res.last_out),
    .i_res_ovf   (o_res.overflow)
);

`default_nettype wire
